/* sv/qrlm_pkg.sv */
// qrlm_pkg: shared types and constants of the quantified run line matcher
// no dependencies; imported by every module of the block except qrlm_ram
package qrlm_pkg;

    localparam logic [2:0] OP_CLEAR     = 3'd0;
    localparam logic [2:0] OP_PAT_BYTE  = 3'd1;
    localparam logic [2:0] OP_PAT_END   = 3'd2;
    localparam logic [2:0] OP_TEXT_BYTE = 3'd3;
    localparam logic [2:0] OP_LINE_END  = 3'd4;

    localparam logic [1:0] QK_OPT  = 2'd0;
    localparam logic [1:0] QK_PLUS = 2'd1;
    localparam logic [1:0] QK_STAR = 2'd2;

    localparam logic [7:0] ESC_BYTE   = 8'h5C;
    localparam logic [7:0] BYTE_OPT   = 8'h3F;
    localparam logic [7:0] BYTE_PLUS  = 8'h2B;
    localparam logic [7:0] BYTE_STAR  = 8'h2A;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [2:0] {
        CMD_NOP,
        CMD_CLEAR,
        CMD_PAT,
        CMD_END,
        CMD_TEXT,
        CMD_LINE
    } cmd_t;

    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] data;
    } item_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TXT_RD,
        S_TXT_CMP,
        S_LE_CMP,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_EMIT
    } state_t;

endpackage

/* sv/quantified_run_line_match.sv */
// quantified_run_line_match: top level, front queue, run compiler and matcher
// depends on qrlm_pkg, qrlm_front, qrlm_back and qrlm_ram
//
// Pattern bytes build a table of runs (character, minimum, maximum repeat) in a
// MAX_RUNS deep ram; text bytes of a line are matched against it greedily and
// an end of line gives one verdict transaction, a pattern end one status
// transaction. A two entry input queue decouples acceptance from execution.
// Clear and pattern byte execute in the idle state; pattern end executes and
// then loads the output register, after any wait for that register to be free.
// A text byte reads the current run from the registered ram and compares, and
// repeats the read and compare for each optional run skipped in the skip loop;
// once the line has already failed there is no compare. An end of line emits
// at once when the verdict is settled, compares the current run to its minimum
// otherwise, and unless it falls short scans the runs after the current one for
// a nonzero minimum, then waits for the output register.
// No clearing pass after reset.
module quantified_run_line_match
    import qrlm_pkg::*;
#(
    parameter int MAX_RUNS   = 256,
    parameter int MAX_REPEAT = 2047
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [1:0] cfg_wdata,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [2:0] operation,
    input  logic [7:0] byte_value,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       result_kind,
    output logic       matched,
    output logic       pattern_error
);

    logic [1:0]                    quant_kind_reg;
    logic                          q_valid;
    item_t                         q_item;
    logic                          q_pop;
    logic [1:0]                    q_count;
    logic [$clog2(MAX_RUNS+1)-1:0] run_total;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quant_kind_reg <= QK_OPT;
        end
        else if (cfg_we)
        begin
            quant_kind_reg <= cfg_wdata;
        end
    end

    qrlm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .operation  (operation),
        .byte_value (byte_value),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop),
        .q_count    (q_count)
    );

    qrlm_back #(
        .MAX_RUNS   (MAX_RUNS),
        .MAX_REPEAT (MAX_REPEAT)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .quant_kind    (quant_kind_reg),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .result_kind   (result_kind),
        .matched       (matched),
        .pattern_error (pattern_error),
        .run_total     (run_total)
    );

    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        run_total <= ($clog2(MAX_RUNS+1))'(MAX_RUNS))
        else $error("run table count beyond capacity");

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_count <= 2'(QUEUE_DEPTH) && (in_ready == (q_count != 2'(QUEUE_DEPTH))))
        else $error("input queue count inconsistent");

    a_pop_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

    a_status_no_match: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !result_kind) |-> !matched)
        else $error("pattern status reports a match");

endmodule

/* sv/qrlm_ram.sv */
// qrlm_ram: generic single write, single read ram with registered read data
// no dependencies
module qrlm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* sv/qrlm_front.sv */
// qrlm_front: accepts input transactions, decodes the operation and queues them
// depends on qrlm_pkg
module qrlm_front
    import qrlm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [2:0] operation,
    input  logic [7:0] byte_value,
    output logic       q_valid,
    output item_t      q_item,
    input  logic       q_pop,
    output logic [1:0] q_count
);

    item_t      q_mem_reg [QUEUE_DEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    item_t      dec;
    logic       push;

    always_comb
    begin
        dec.data = byte_value;
        case (operation)
            OP_CLEAR:     dec.cmd = CMD_CLEAR;
            OP_PAT_BYTE:  dec.cmd = CMD_PAT;
            OP_PAT_END:   dec.cmd = CMD_END;
            OP_TEXT_BYTE: dec.cmd = CMD_TEXT;
            OP_LINE_END:  dec.cmd = CMD_LINE;
            default:      dec.cmd = CMD_NOP;
        endcase
    end

    assign in_ready = (count_reg != 2'(QUEUE_DEPTH));
    assign push     = in_valid && in_ready;
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = q_mem_reg[rd_ptr_reg];
    assign q_count  = count_reg;

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= dec;
        end
    end

endmodule

/* sv/qrlm_back.sv */
// qrlm_back: compiles pattern bytes into runs and matches text against them
// depends on qrlm_pkg and qrlm_ram
module qrlm_back
    import qrlm_pkg::*;
#(
    parameter int MAX_RUNS   = 256,
    parameter int MAX_REPEAT = 2047
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [1:0]                    quant_kind,
    input  logic                          q_valid,
    input  item_t                         q_item,
    output logic                          q_pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          result_kind,
    output logic                          matched,
    output logic                          pattern_error,
    output logic [$clog2(MAX_RUNS+1)-1:0] run_total
);

    localparam int IW = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1;
    localparam int RD = (MAX_RUNS > 1) ? MAX_RUNS : 2;
    localparam int TW = $clog2(MAX_RUNS + 1);
    localparam int CW = $clog2(MAX_REPEAT + 1);
    localparam int EW = 8 + 2 * CW + 1;
    localparam logic [CW-1:0] REP_MAX = CW'(MAX_REPEAT);
    localparam logic [CW-1:0] ONE     = CW'(1);

    function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
        return (v >= REP_MAX) ? REP_MAX : CW'(v + ONE);
    endfunction

    state_t        state_reg, state_next;
    logic [TW-1:0] total_reg, total_next;
    logic          esc_reg, esc_next;
    logic          qused_reg, qused_next;
    logic          first_reg, first_next;
    logic          bad_reg, bad_next;
    logic [TW-1:0] j_reg, j_next;
    logic [CW-1:0] rc_reg, rc_next;
    logic          failed_reg, failed_next;
    logic [7:0]    lc_reg, lc_next;
    logic [CW-1:0] lmin_reg, lmin_next;
    logic [CW-1:0] lmax_reg, lmax_next;
    logic          lunl_reg, lunl_next;
    logic [7:0]    txt_reg, txt_next;
    logic          rkind_reg, rkind_next;
    logic          rmatch_reg, rmatch_next;
    logic          rerr_reg, rerr_next;
    logic          ov_reg, ov_next;
    logic          ok_reg, ok_next;
    logic          om_reg, om_next;
    logic          oe_reg, oe_next;

    logic          we;
    logic [IW-1:0] waddr;
    logic [EW-1:0] wdata;
    logic [EW-1:0] rdata;
    logic [7:0]    rd_char;
    logic [CW-1:0] rd_min, rd_max;
    logic          rd_unl;
    logic [TW-1:0] last_idx;
    logic [7:0]    qbyte;
    logic          qbyte_ok;
    logic          slot_free;
    logic          err;
    logic [7:0]    b;

    assign {rd_char, rd_min, rd_max, rd_unl} = rdata;
    assign last_idx  = total_reg - TW'(1);
    assign slot_free = !ov_reg || out_ready;
    assign b         = q_item.data;
    assign err       = bad_reg || esc_reg;

    always_comb
    begin
        qbyte_ok = 1'b1;
        case (quant_kind)
            QK_OPT:  qbyte = BYTE_OPT;
            QK_PLUS: qbyte = BYTE_PLUS;
            QK_STAR: qbyte = BYTE_STAR;
            default:
            begin
                qbyte    = 8'h00;
                qbyte_ok = 1'b0;
            end
        endcase
    end

    qrlm_ram #(
        .WIDTH (EW),
        .DEPTH (RD)
    ) u_runs (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (j_reg[IW-1:0]),
        .rdata (rdata)
    );

    always_comb
    begin
        state_next  = state_reg;
        total_next  = total_reg;
        esc_next    = esc_reg;
        qused_next  = qused_reg;
        first_next  = first_reg;
        bad_next    = bad_reg;
        j_next      = j_reg;
        rc_next     = rc_reg;
        failed_next = failed_reg;
        lc_next     = lc_reg;
        lmin_next   = lmin_reg;
        lmax_next   = lmax_reg;
        lunl_next   = lunl_reg;
        txt_next    = txt_reg;
        rkind_next  = rkind_reg;
        rmatch_next = rmatch_reg;
        rerr_next   = rerr_reg;
        ok_next     = ok_reg;
        om_next     = om_reg;
        oe_next     = oe_reg;
        ov_next     = ov_reg && !out_ready;
        q_pop       = 1'b0;
        we          = 1'b0;
        waddr       = last_idx[IW-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    case (q_item.cmd)
                        CMD_CLEAR:
                        begin
                            total_next  = '0;
                            esc_next    = 1'b0;
                            qused_next  = 1'b0;
                            first_next  = 1'b0;
                            bad_next    = 1'b0;
                            j_next      = '0;
                            rc_next     = '0;
                            failed_next = 1'b0;
                        end
                        CMD_PAT:
                        begin
                            first_next = 1'b1;
                            if (!esc_reg && b == ESC_BYTE)
                            begin
                                esc_next = 1'b1;
                            end
                            else if (!esc_reg && first_reg && qbyte_ok && b == qbyte
                                     && total_reg != '0)
                            begin
                                if (!qused_reg)
                                begin
                                    qused_next = 1'b1;
                                    we         = 1'b1;
                                    if (quant_kind != QK_PLUS && lmin_reg != '0)
                                    begin
                                        lmin_next = lmin_reg - ONE;
                                    end
                                    if (quant_kind != QK_OPT)
                                    begin
                                        lunl_next = 1'b1;
                                    end
                                end
                            end
                            else
                            begin
                                // literal, escaped or plain
                                esc_next   = 1'b0;
                                qused_next = 1'b0;
                                if (total_reg != '0 && lc_reg == b)
                                begin
                                    we        = 1'b1;
                                    lmin_next = sat_inc(lmin_reg);
                                    lmax_next = sat_inc(lmax_reg);
                                end
                                else if (total_reg >= TW'(MAX_RUNS))
                                begin
                                    bad_next = 1'b1;
                                end
                                else
                                begin
                                    we         = 1'b1;
                                    waddr      = total_reg[IW-1:0];
                                    lc_next    = b;
                                    lmin_next  = ONE;
                                    lmax_next  = ONE;
                                    lunl_next  = 1'b0;
                                    total_next = total_reg + TW'(1);
                                end
                            end
                        end
                        CMD_END:
                        begin
                            bad_next    = err;
                            esc_next    = 1'b0;
                            rkind_next  = 1'b0;
                            rmatch_next = 1'b0;
                            rerr_next   = err;
                            state_next  = S_EMIT;
                        end
                        CMD_TEXT:
                        begin
                            txt_next   = b;
                            state_next = S_TXT_RD;
                        end
                        CMD_LINE:
                        begin
                            rkind_next  = 1'b1;
                            rerr_next   = err;
                            rmatch_next = 1'b0;
                            if (err || failed_reg)
                            begin
                                state_next = S_EMIT;
                            end
                            else if (j_reg >= total_reg)
                            begin
                                rmatch_next = 1'b1;
                                state_next  = S_EMIT;
                            end
                            else
                            begin
                                state_next = S_LE_CMP;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_TXT_RD:
            begin
                if (failed_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (j_reg >= total_reg)
                begin
                    failed_next = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    state_next = S_TXT_CMP;
                end
            end
            S_TXT_CMP:
            begin
                if (txt_reg == rd_char)
                begin
                    if (!rd_unl && rc_reg >= rd_max)
                    begin
                        failed_next = 1'b1;
                    end
                    else
                    begin
                        rc_next = sat_inc(rc_reg);
                    end
                    state_next = S_IDLE;
                end
                else if (rc_reg < rd_min)
                begin
                    failed_next = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    // skip past an exhausted run and retry
                    j_next     = j_reg + TW'(1);
                    rc_next    = '0;
                    state_next = S_TXT_RD;
                end
            end
            S_LE_CMP:
            begin
                if (rc_reg < rd_min)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    j_next     = j_reg + TW'(1);
                    state_next = S_SCAN_RD;
                end
            end
            S_SCAN_RD:
            begin
                if (j_reg >= total_reg)
                begin
                    rmatch_next = 1'b1;
                    state_next  = S_EMIT;
                end
                else
                begin
                    state_next = S_SCAN_CMP;
                end
            end
            S_SCAN_CMP:
            begin
                if (rd_min != '0)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    j_next     = j_reg + TW'(1);
                    state_next = S_SCAN_RD;
                end
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    ov_next     = 1'b1;
                    ok_next     = rkind_reg;
                    om_next     = rmatch_reg;
                    oe_next     = rerr_reg;
                    j_next      = '0;
                    rc_next     = '0;
                    failed_next = 1'b0;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign wdata = {lc_next, lmin_next, lmax_next, lunl_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            total_reg  <= '0;
            esc_reg    <= 1'b0;
            qused_reg  <= 1'b0;
            first_reg  <= 1'b0;
            bad_reg    <= 1'b0;
            j_reg      <= '0;
            rc_reg     <= '0;
            failed_reg <= 1'b0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            total_reg  <= total_next;
            esc_reg    <= esc_next;
            qused_reg  <= qused_next;
            first_reg  <= first_next;
            bad_reg    <= bad_next;
            j_reg      <= j_next;
            rc_reg     <= rc_next;
            failed_reg <= failed_next;
            ov_reg     <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lc_reg     <= lc_next;
        lmin_reg   <= lmin_next;
        lmax_reg   <= lmax_next;
        lunl_reg   <= lunl_next;
        txt_reg    <= txt_next;
        rkind_reg  <= rkind_next;
        rmatch_reg <= rmatch_next;
        rerr_reg   <= rerr_next;
        ok_reg     <= ok_next;
        om_reg     <= om_next;
        oe_reg     <= oe_next;
    end

    assign out_valid     = ov_reg;
    assign result_kind   = ok_reg;
    assign matched       = om_reg;
    assign pattern_error = oe_reg;
    assign run_total     = total_reg;

endmodule

/* sim/tb_quantified_run_line_match.sv */
// tb_quantified_run_line_match: self-checking testbench of the run line matcher
// depends on qrlm_pkg and quantified_run_line_match; predicts verdicts in the bench
module tb_quantified_run_line_match;
    import qrlm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RUNS_MAX   = 256;
    localparam int REPEAT_MAX = 2047;
    localparam int WATCHDOG_LIMIT = 200000;

    // quantifier kind with no quantifier byte, and operation codes with no meaning
    localparam logic [1:0] QK_NONE  = 2'd3;
    localparam logic [2:0] OP_RSVD5 = 3'd5;
    localparam logic [2:0] OP_RSVD6 = 3'd6;
    localparam logic [2:0] OP_RSVD7 = 3'd7;

    typedef struct packed {
        logic kind;
        logic hit;
        logic err;
    } verdict_t;

    typedef logic [7:0] bytes_t[$];

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [1:0] cfg_wdata;
    logic       in_valid;
    logic       in_ready;
    logic [2:0] operation;
    logic [7:0] byte_value;
    logic       out_valid;
    logic       out_ready;
    logic       result_kind;
    logic       matched;
    logic       pattern_error;

    quantified_run_line_match u_dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_ready(in_ready), .operation(operation),
        .byte_value(byte_value), .out_valid(out_valid), .out_ready(out_ready),
        .result_kind(result_kind), .matched(matched), .pattern_error(pattern_error)
    );

    // predictor state
    logic [1:0]  qkind;
    logic [7:0]  rchar [RUNS_MAX];
    int          rmin  [RUNS_MAX];
    int          rmax  [RUNS_MAX];
    bit          runl  [RUNS_MAX];
    int          nruns;
    bit          esc_pend, quant_done, seen_first, pat_bad;
    int          cur_run, reps;
    bit          line_bad;

    verdict_t    verdicts_due[$];
    int          errors;
    int          sent_items, got_results;
    int          send_idle_pct, recv_idle_pct;
    bit          recv_hold;
    int          quiet_cycles;

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int sat_up(int v);
        return (v >= REPEAT_MAX) ? REPEAT_MAX : v + 1;
    endfunction

    function automatic void restart_matching();
        cur_run = 0;
        reps = 0;
        line_bad = 0;
    endfunction

    function automatic void push_literal(logic [7:0] b);
        quant_done = 0;
        if (nruns > 0 && rchar[nruns-1] == b)
        begin
            rmin[nruns-1] = sat_up(rmin[nruns-1]);
            rmax[nruns-1] = sat_up(rmax[nruns-1]);
        end
        else if (nruns >= RUNS_MAX)
            pat_bad = 1;
        else
        begin
            rchar[nruns] = b;
            rmin[nruns] = 1;
            rmax[nruns] = 1;
            runl[nruns] = 0;
            nruns++;
        end
    endfunction

    function automatic bit is_quant(logic [7:0] b);
        case (qkind)
            QK_OPT:  return b == BYTE_OPT;
            QK_PLUS: return b == BYTE_PLUS;
            QK_STAR: return b == BYTE_STAR;
            default: return 0;
        endcase
    endfunction

    function automatic void compile_byte(logic [7:0] b);
        bit first;
        first = !seen_first;
        seen_first = 1;
        if (esc_pend)
        begin
            esc_pend = 0;
            push_literal(b);
        end
        else if (b == ESC_BYTE)
            esc_pend = 1;
        else if (!first && is_quant(b) && nruns > 0)
        begin
            if (!quant_done)
            begin
                if ((qkind == QK_OPT || qkind == QK_STAR) && rmin[nruns-1] > 0)
                    rmin[nruns-1]--;
                if (qkind == QK_PLUS || qkind == QK_STAR)
                    runl[nruns-1] = 1;
                quant_done = 1;
            end
        end
        else
            push_literal(b);
    endfunction

    function automatic void match_text(logic [7:0] c);
        while (!line_bad)
        begin
            if (cur_run >= nruns)
            begin
                line_bad = 1;
                return;
            end
            if (c == rchar[cur_run])
            begin
                if (!runl[cur_run] && reps >= rmax[cur_run])
                    line_bad = 1;
                else
                    reps = sat_up(reps);
                return;
            end
            if (reps < rmin[cur_run])
            begin
                line_bad = 1;
                return;
            end
            cur_run++;
            reps = 0;
        end
    endfunction

    function automatic bit line_ok();
        if (line_bad)
            return 0;
        if (cur_run >= nruns)
            return 1;
        if (reps < rmin[cur_run])
            return 0;
        for (int j = cur_run + 1; j < nruns; j++)
            if (rmin[j] > 0)
                return 0;
        return 1;
    endfunction

    function automatic void predict_item(logic [2:0] op, logic [7:0] b);
        verdict_t v;
        bit e;
        case (op)
            OP_CLEAR:
            begin
                nruns = 0;
                esc_pend = 0;
                quant_done = 0;
                seen_first = 0;
                pat_bad = 0;
                restart_matching();
            end
            OP_PAT_BYTE: compile_byte(b);
            OP_PAT_END:
            begin
                if (esc_pend)
                begin
                    pat_bad = 1;
                    esc_pend = 0;
                end
                restart_matching();
                v = '{kind: 1'b0, hit: 1'b0, err: pat_bad};
                verdicts_due.push_back(v);
            end
            OP_TEXT_BYTE: match_text(b);
            OP_LINE_END:
            begin
                e = pat_bad || esc_pend;
                v = '{kind: 1'b1, hit: !e && line_ok(), err: e};
                verdicts_due.push_back(v);
                restart_matching();
            end
            default: ;
        endcase
    endfunction

    function automatic bytes_t str_bytes(string s);
        bytes_t q;
        foreach (s[i])
            q.push_back(s[i]);
        return q;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want,
                 got_results);
        errors++;
    endtask

    // sender: one transaction, valid held until accepted
    task automatic send_item(logic [2:0] op, logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        operation <= op;
        byte_value <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_item(op, b);
        sent_items++;
    endtask

    task automatic stop_sending();
        in_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        stop_sending();
        while (verdicts_due.size() != 0)
            @(posedge clk);
        repeat (600) @(posedge clk);
    endtask

    task automatic set_quantifier(logic [1:0] k);
        wait_drained();
        cfg_we <= 1'b1;
        cfg_wdata <= k;
        @(posedge clk);
        cfg_we <= 1'b0;
        qkind = k;
    endtask

    // receiver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                got_results++;
                if (verdicts_due.size() == 0)
                begin
                    report_mismatch("unexpected result", 1, 0);
                end
                else
                begin
                    verdict_t w;
                    w = verdicts_due.pop_front();
                    if (result_kind !== w.kind)
                        report_mismatch("result_kind", result_kind, w.kind);
                    if (matched !== w.hit)
                        report_mismatch("matched", matched, w.hit);
                    if (pattern_error !== w.err)
                        report_mismatch("pattern_error", pattern_error, w.err);
                end
            end
            out_ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired");
            $display("FAIL quantified_run_line_match");
            $finish;
        end
    end

    function automatic logic [7:0] pick_byte(bytes_t alphabet);
        return alphabet[$urandom_range(alphabet.size() - 1)];
    endfunction

    task automatic send_pattern(bytes_t p);
        send_item(OP_CLEAR, 8'($urandom));
        foreach (p[i])
            send_item(OP_PAT_BYTE, p[i]);
        send_item(OP_PAT_END, 8'($urandom));
    endtask

    task automatic send_line(bytes_t t);
        foreach (t[i])
            send_item(OP_TEXT_BYTE, t[i]);
        send_item(OP_LINE_END, 8'($urandom));
    endtask

    task automatic test_directed();
        bytes_t z;
        z = {8'h00, 8'hFF, 8'hFF};
        send_pattern(str_bytes("?ab?c+d*"));
        send_line(str_bytes("?abcd"));
        send_line(str_bytes("?ac"));
        send_pattern(str_bytes("\\?a??"));
        send_line(str_bytes("?"));
        send_line(str_bytes("?a"));
        send_item(OP_PAT_BYTE, ESC_BYTE);
        send_item(OP_LINE_END, 8'h00);
        send_item(OP_PAT_END, 8'hFF);
        send_line(str_bytes("x"));
        send_pattern(z);
        send_line(z);
        send_item(OP_TEXT_BYTE, 8'h0A);
        send_item(OP_RSVD5, 8'h55);
        send_item(OP_RSVD7, 8'hAA);
        send_item(OP_RSVD6, 8'h12);
        send_item(OP_LINE_END, 8'h00);
        send_item(OP_PAT_BYTE, 8'h7F);
        send_item(OP_PAT_END, 8'h00);
    endtask

    // a long run checked at and past its length, many distinct bytes overflow the table
    task automatic test_long_run_overflow();
        send_item(OP_CLEAR, 8'h00);
        repeat (40) send_item(OP_PAT_BYTE, 8'h61);
        send_item(OP_PAT_END, 8'h00);
        repeat (40) send_item(OP_TEXT_BYTE, 8'h61);
        send_item(OP_LINE_END, 8'h00);
        repeat (41) send_item(OP_TEXT_BYTE, 8'h61);
        send_item(OP_LINE_END, 8'h00);
        send_item(OP_CLEAR, 8'h00);
        for (int i = 0; i < 260; i++)
            send_item(OP_PAT_BYTE, 8'(i * 2 + (i >= 46 ? 1 : 0)));
        send_item(OP_PAT_END, 8'h00);
        send_line(str_bytes("ab"));
    endtask

    task automatic test_random(int items);
        bytes_t alpha;
        bytes_t tail;
        bytes_t p;
        bytes_t t;
        int plen;
        int start;
        alpha = str_bytes("abc");
        alpha.push_back(BYTE_OPT);
        alpha.push_back(BYTE_PLUS);
        alpha.push_back(BYTE_STAR);
        alpha.push_back(ESC_BYTE);
        tail = str_bytes("abc?+*");
        start = sent_items;
        while (sent_items - start < items)
        begin
            if ($urandom_range(9) == 0)
            begin
                send_item(3'($urandom), 8'($urandom));
                continue;
            end
            plen = $urandom_range(1, 8);
            p.delete();
            for (int i = 0; i < plen; i++)
                p.push_back(($urandom_range(15) == 0) ? 8'($urandom) : pick_byte(alpha));
            send_pattern(p);
            repeat ($urandom_range(1, 4))
            begin
                t.delete();
                repeat ($urandom_range(0, 8))
                    t.push_back(($urandom_range(19) == 0) ? 8'($urandom) : pick_byte(tail));
                send_line(t);
            end
        end
    endtask

    task automatic test_backpressure();
        recv_hold = 1'b1;
        fork
            begin
                repeat (400) @(posedge clk);
                recv_hold = 1'b0;
            end
            begin
                send_pattern(str_bytes("ab"));
                repeat (6) send_line(str_bytes("ab"));
                stop_sending();
            end
        join
        wait_drained();
    endtask

    initial
    begin
        errors = 0;
        sent_items = 0;
        got_results = 0;
        recv_hold = 0;
        quiet_cycles = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = QK_OPT;
        in_valid = 1'b0;
        operation = OP_CLEAR;
        byte_value = 8'h00;
        out_ready = 1'b0;
        send_idle_pct = 21;
        recv_idle_pct = 70;
        qkind = QK_OPT;
        nruns = 0;
        esc_pend = 0;
        quant_done = 0;
        seen_first = 0;
        pat_bad = 0;
        restart_matching();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        set_quantifier(QK_PLUS);
        test_directed();
        set_quantifier(QK_STAR);
        test_directed();
        set_quantifier(QK_NONE);
        test_directed();
        test_long_run_overflow();
        test_backpressure();

        set_quantifier(QK_OPT);
        test_random(200);
        send_idle_pct = 70;
        recv_idle_pct = 21;
        set_quantifier(QK_PLUS);
        test_random(200);
        set_quantifier(QK_STAR);
        test_random(200);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_quantifier(QK_NONE);
        test_random(250);
        set_quantifier(QK_OPT);
        test_random(250);

        wait_drained();
        $display("covered %0d input transactions and %0d result transactions", sent_items,
                 got_results);
        $display("all quantifier kinds, escapes, long runs, overflow and back-pressure");
        if (errors == 0)
            $display("PASS quantified_run_line_match");
        else
            $display("FAIL quantified_run_line_match");
        $finish;
    end
endmodule
